// ===== design/quaternion_product_and_rotate_assert.svh =====
// Assertion macros for the quaternion product and rotate unit
`ifndef QUATERNION_PRODUCT_AND_ROTATE_ASSERT_SVH
`define QUATERNION_PRODUCT_AND_ROTATE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define QPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpr assertion failed");

// next-cycle implication, checked out of reset
`define QPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpr assertion failed");

`endif

// ===== design/qpr_pkg.sv =====
// Package: types, widths and rounding helpers of the quaternion unit
`default_nettype none

package qpr_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COMP_W    = 16;
    localparam int MID_W     = COMP_W + 2;
    localparam int P_W       = MID_W;
    localparam int Q_W       = COMP_W + 1;
    localparam int PROD_W    = P_W + Q_W;
    localparam int SUM_W     = PROD_W + 2;

    localparam logic signed [SUM_W-1:0] HALF     = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] MID_MAX  = SUM_W'((64'sd1 <<< (MID_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] MID_MIN  = ~MID_MAX;
    localparam logic signed [SUM_W-1:0] COMP_MAX = SUM_W'((64'sd1 <<< (COMP_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] COMP_MIN = ~COMP_MAX;

    typedef enum logic
    {
        OP_PRODUCT = 1'b0,
        OP_ROTATE  = 1'b1
    } op_t;

    typedef struct packed
    {
        logic                     op;
        logic signed [COMP_W-1:0] a_w;
        logic signed [COMP_W-1:0] a_x;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] b_w;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_z;
    } cmd_t;

    typedef struct packed
    {
        logic signed [COMP_W-1:0] r_w;
        logic signed [COMP_W-1:0] r_x;
        logic signed [COMP_W-1:0] r_y;
        logic signed [COMP_W-1:0] r_z;
        logic                     saturated;
    } res_t;

    typedef struct packed
    {
        logic signed [P_W-1:0] w;
        logic signed [P_W-1:0] x;
        logic signed [P_W-1:0] y;
        logic signed [P_W-1:0] z;
    } p_quat_t;

    typedef struct packed
    {
        logic signed [Q_W-1:0] w;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } q_quat_t;

    typedef struct packed
    {
        logic signed [SUM_W-1:0] w;
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum_quat_t;

    typedef struct packed
    {
        logic prod;
        logic sum;
    } ham_en_t;

    typedef struct packed
    {
        logic signed [MID_W-1:0] v;
        logic                    clip;
    } mid_sat_t;

    typedef struct packed
    {
        logic signed [COMP_W-1:0] v;
        logic                     clip;
    } comp_sat_t;

    // nearest, ties toward plus infinity
    function automatic logic signed [SUM_W-1:0] round_fx(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        t = s + HALF;
        return t >>> FRAC_BITS;
    endfunction

    function automatic mid_sat_t sat_mid(input logic signed [SUM_W-1:0] s);
        mid_sat_t r;
        r.clip = 1'b0;
        if (s > MID_MAX)
        begin
            r.v    = MID_MAX[MID_W-1:0];
            r.clip = 1'b1;
        end
        else if (s < MID_MIN)
        begin
            r.v    = MID_MIN[MID_W-1:0];
            r.clip = 1'b1;
        end
        else
        begin
            r.v = s[MID_W-1:0];
        end
        return r;
    endfunction

    function automatic comp_sat_t sat_comp(input logic signed [SUM_W-1:0] s);
        comp_sat_t r;
        r.clip = 1'b0;
        if (s > COMP_MAX)
        begin
            r.v    = COMP_MAX[COMP_W-1:0];
            r.clip = 1'b1;
        end
        else if (s < COMP_MIN)
        begin
            r.v    = COMP_MIN[COMP_W-1:0];
            r.clip = 1'b1;
        end
        else
        begin
            r.v = s[COMP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/qpr_hamilton.sv =====
// Two-stage Hamilton product: registered partial products, then registered sums
`default_nettype none

module qpr_hamilton
(
    input  wire logic               clk,
    input  wire qpr_pkg::ham_en_t   en,
    input  wire qpr_pkg::p_quat_t   p,
    input  wire qpr_pkg::q_quat_t   q,
    output qpr_pkg::sum_quat_t      sum
);

    logic signed [qpr_pkg::P_W-1:0]    pv [4];
    logic signed [qpr_pkg::Q_W-1:0]    qv [4];
    logic signed [qpr_pkg::PROD_W-1:0] prod_reg [4][4];
    qpr_pkg::sum_quat_t                sum_reg;
    qpr_pkg::sum_quat_t                sum_next;

    assign pv[0] = p.w;
    assign pv[1] = p.x;
    assign pv[2] = p.y;
    assign pv[3] = p.z;
    assign qv[0] = q.w;
    assign qv[1] = q.x;
    assign qv[2] = q.y;
    assign qv[3] = q.z;

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i][j] <= pv[i] * qv[j];
                end
            end
        end
    end

    always_comb
    begin
        sum_next.w = qpr_pkg::SUM_W'(prod_reg[0][0]) - qpr_pkg::SUM_W'(prod_reg[1][1])
                   - qpr_pkg::SUM_W'(prod_reg[2][2]) - qpr_pkg::SUM_W'(prod_reg[3][3]);
        sum_next.x = qpr_pkg::SUM_W'(prod_reg[0][1]) + qpr_pkg::SUM_W'(prod_reg[1][0])
                   + qpr_pkg::SUM_W'(prod_reg[2][3]) - qpr_pkg::SUM_W'(prod_reg[3][2]);
        sum_next.y = qpr_pkg::SUM_W'(prod_reg[0][2]) - qpr_pkg::SUM_W'(prod_reg[1][3])
                   + qpr_pkg::SUM_W'(prod_reg[2][0]) + qpr_pkg::SUM_W'(prod_reg[3][1]);
        sum_next.z = qpr_pkg::SUM_W'(prod_reg[0][3]) + qpr_pkg::SUM_W'(prod_reg[1][2])
                   - qpr_pkg::SUM_W'(prod_reg[2][1]) + qpr_pkg::SUM_W'(prod_reg[3][0]);
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ===== design/quaternion_product_and_rotate.sv =====
// Quaternion product and vector rotation unit: top level, six-stage pipeline
//
// Items enter on cmd (cmd_valid / cmd_stall) and leave on res (res_valid / res_stall).
// op = product gives A*B; op = rotate gives A*(v,0)*conj(A) with v = b_x, b_y, b_z
// and r_w forced to zero. Components are Q1.14; saturated flags any clipping,
// including clipping of the 18-bit rotation intermediate.
// An accepted item passes through stages 1 to 6 and is presented on res from the output
// register. Throughput: one item per cycle when nothing stalls; each of the six stages holds one
// item, and the two multiplier banks set the stage count.
// res_stall holds the output register; stages behind it keep filling empty slots,
// so cmd_stall rises only once all six stages hold items and the output is stalled.
// Nothing is lost or repeated across a stall.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none

module quaternion_product_and_rotate
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire qpr_pkg::cmd_t  cmd,
    output logic                res_valid,
    input  wire logic           res_stall,
    output qpr_pkg::res_t       res
);

    logic [6:1] v_reg;
    logic [6:1] en;

    logic [2:1] op_reg;
    logic       op3_reg;
    logic       op4_reg;
    logic       op5_reg;
    logic       op6_reg;
    logic signed [qpr_pkg::COMP_W-1:0] a1_reg [4];
    logic signed [qpr_pkg::COMP_W-1:0] a2_reg [4];
    logic signed [qpr_pkg::MID_W-1:0]  mid3_reg [4];
    logic signed [qpr_pkg::MID_W-1:0]  mid3_next [4];
    logic signed [qpr_pkg::COMP_W-1:0] mid4_reg [4];
    logic signed [qpr_pkg::COMP_W-1:0] mid5_reg [4];
    logic                              flag3_reg, flag3_next;
    logic                              flag4_reg, flag5_reg;
    qpr_pkg::q_quat_t                  cj3_reg;
    qpr_pkg::res_t                     res_reg, res_next;

    qpr_pkg::p_quat_t   p1, p2;
    qpr_pkg::q_quat_t   q1;
    qpr_pkg::sum_quat_t sum1, sum2;
    qpr_pkg::ham_en_t   en_h1, en_h2;
    logic signed [qpr_pkg::SUM_W-1:0] s1 [4];
    logic signed [qpr_pkg::SUM_W-1:0] s2 [4];

    // a stage moves when its successor is empty or moving
    always_comb
    begin
        en[6] = !v_reg[6] || !res_stall;
        for (int k = 5; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign cmd_stall = !en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= cmd_valid;
            end
            for (int k = 2; k <= 6; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // first product: A * B, with B's scalar cleared for rotation
    assign p1.w = qpr_pkg::P_W'(cmd.a_w);
    assign p1.x = qpr_pkg::P_W'(cmd.a_x);
    assign p1.y = qpr_pkg::P_W'(cmd.a_y);
    assign p1.z = qpr_pkg::P_W'(cmd.a_z);
    assign q1.w = (cmd.op == qpr_pkg::OP_ROTATE) ? '0 : qpr_pkg::Q_W'(cmd.b_w);
    assign q1.x = qpr_pkg::Q_W'(cmd.b_x);
    assign q1.y = qpr_pkg::Q_W'(cmd.b_y);
    assign q1.z = qpr_pkg::Q_W'(cmd.b_z);

    assign en_h1.prod = en[1];
    assign en_h1.sum  = en[2];

    qpr_hamilton u_ham1
    (
        .clk (clk),
        .en  (en_h1),
        .p   (p1),
        .q   (q1),
        .sum (sum1)
    );

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            op_reg[1] <= cmd.op;
            a1_reg[0] <= cmd.a_w;
            a1_reg[1] <= cmd.a_x;
            a1_reg[2] <= cmd.a_y;
            a1_reg[3] <= cmd.a_z;
        end
        if (en[2])
        begin
            op_reg[2] <= op_reg[1];
            a2_reg    <= a1_reg;
        end
    end

    // round and clip the first product
    assign s1[0] = sum1.w;
    assign s1[1] = sum1.x;
    assign s1[2] = sum1.y;
    assign s1[3] = sum1.z;

    always_comb
    begin
        qpr_pkg::mid_sat_t  ms;
        qpr_pkg::comp_sat_t cs;
        logic signed [qpr_pkg::SUM_W-1:0] rv;
        flag3_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            rv = qpr_pkg::round_fx(s1[i]);
            ms = qpr_pkg::sat_mid(rv);
            cs = qpr_pkg::sat_comp(rv);
            if (op_reg[2] == qpr_pkg::OP_ROTATE)
            begin
                mid3_next[i] = ms.v;
                flag3_next   = flag3_next | ms.clip;
            end
            else
            begin
                mid3_next[i] = qpr_pkg::MID_W'(cs.v);
                flag3_next   = flag3_next | cs.clip;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            op3_reg   <= op_reg[2];
            mid3_reg  <= mid3_next;
            flag3_reg <= flag3_next;
            cj3_reg.w <= qpr_pkg::Q_W'(a2_reg[0]);
            cj3_reg.x <= -qpr_pkg::Q_W'(a2_reg[1]);
            cj3_reg.y <= -qpr_pkg::Q_W'(a2_reg[2]);
            cj3_reg.z <= -qpr_pkg::Q_W'(a2_reg[3]);
        end
    end

    // second product: T * conj(A)
    assign p2.w = mid3_reg[0];
    assign p2.x = mid3_reg[1];
    assign p2.y = mid3_reg[2];
    assign p2.z = mid3_reg[3];

    assign en_h2.prod = en[4];
    assign en_h2.sum  = en[5];

    qpr_hamilton u_ham2
    (
        .clk (clk),
        .en  (en_h2),
        .p   (p2),
        .q   (cj3_reg),
        .sum (sum2)
    );

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            op4_reg   <= op3_reg;
            flag4_reg <= flag3_reg;
            for (int i = 0; i < 4; i++)
            begin
                mid4_reg[i] <= mid3_reg[i][qpr_pkg::COMP_W-1:0];
            end
        end
        if (en[5])
        begin
            op5_reg   <= op4_reg;
            flag5_reg <= flag4_reg;
            mid5_reg  <= mid4_reg;
        end
    end

    assign s2[0] = sum2.w;
    assign s2[1] = sum2.x;
    assign s2[2] = sum2.y;
    assign s2[3] = sum2.z;

    always_comb
    begin
        qpr_pkg::comp_sat_t cx, cy, cz;
        cx = qpr_pkg::sat_comp(qpr_pkg::round_fx(s2[1]));
        cy = qpr_pkg::sat_comp(qpr_pkg::round_fx(s2[2]));
        cz = qpr_pkg::sat_comp(qpr_pkg::round_fx(s2[3]));
        if (op5_reg == qpr_pkg::OP_ROTATE)
        begin
            res_next.r_w       = '0;
            res_next.r_x       = cx.v;
            res_next.r_y       = cy.v;
            res_next.r_z       = cz.v;
            res_next.saturated = flag5_reg | cx.clip | cy.clip | cz.clip;
        end
        else
        begin
            res_next.r_w       = mid5_reg[0];
            res_next.r_x       = mid5_reg[1];
            res_next.r_y       = mid5_reg[2];
            res_next.r_z       = mid5_reg[3];
            res_next.saturated = flag5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            op6_reg <= op5_reg;
            res_reg <= res_next;
        end
    end

    assign res_valid = v_reg[6];
    assign res       = res_reg;

`include "quaternion_product_and_rotate_assert.svh"

    // back-pressure only once every stage is occupied
    `QPR_ASSERT_NOW(a_stall_full, cmd_stall, (&v_reg) && res_stall)
    // an item in the last arithmetic stage reaches the output when it moves
    `QPR_ASSERT_NEXT(a_advance, v_reg[5] && en[6], res_valid)
    // rotation results carry a zero scalar
    `QPR_ASSERT_NOW(a_rot_w, res_valid && (op6_reg == qpr_pkg::OP_ROTATE), res.r_w == '0)

endmodule

`default_nettype wire
